@@ sv/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SMM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/smm_pkg.sv @@
// shared types and constants of the shift-add mismatch matcher
package smm_pkg;

  localparam int WORD_BITS     = 64;
  localparam int ALPHABET_SIZE = 256;
  localparam int TIDX_W        = $clog2(ALPHABET_SIZE);
  localparam int POS_W         = 32;
  localparam int FIELD_W       = 6;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = $clog2(QDEPTH);
  localparam int QCNT_W        = $clog2(QDEPTH + 1);

  localparam logic [63:0] ALL_WORD_BITS = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - WORD_BITS);
  localparam logic [POS_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    REG_FIELD_BITS,
    REG_WORD_MASK,
    REG_OVERFLOW_MASK,
    REG_MATCH_LIMIT
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD,
    OP_TEXT
  } op_t;

  typedef struct packed {
    logic [FIELD_W-1:0] field_bits;
    logic [63:0]        word_mask;
    logic [63:0]        overflow_mask;
    logic [63:0]        match_limit;
  } cfg_t;

  // one text byte on its way from front to back
  typedef struct packed {
    logic [63:0]      inc;
    logic             first;
    logic [POS_W-1:0] start;
    logic             last;
  } q_entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

@@ sv/smm_ifs.sv @@
// input and result channel interfaces
interface smm_in_if import smm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [7:0]        table_index;
  logic [63:0]       table_word;
  logic [7:0]        text_byte;
  logic              first_of_text;
  logic [POS_W-1:0]  start_position;
  logic              last_of_text;

  modport source (output valid, operation, table_index, table_word, text_byte,
                  first_of_text, start_position, last_of_text, input ready);
  modport sink (input valid, operation, table_index, table_word, text_byte,
                first_of_text, start_position, last_of_text, output ready);
endinterface

interface smm_out_if import smm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              match_found;
  logic [POS_W-1:0]  match_end;
  logic [POS_W-1:0]  match_count;
  logic              last;

  modport source (output valid, match_found, match_end, match_count, last,
                  input ready);
  modport sink (input valid, match_found, match_end, match_count, last,
                output ready);
endinterface

@@ sv/smm_front.sv @@
// front end: takes transactions, keeps the character table, looks up text bytes
module smm_front import smm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  smm_in_if.sink     items,
  input  q_stat_t    q_stat,
  output logic       q_push,
  output q_entry_t   q_data
);

  logic [63:0]      char_table [ALPHABET_SIZE];
  logic [63:0]      rd_word;
  logic             st_valid;
  logic             st_in_alpha;
  logic             st_first;
  logic [POS_W-1:0] st_start;
  logic             st_last;
  logic             accept;
  logic             is_text;
  logic             in_alpha_idx;
  logic             in_alpha_byte;

  assign items.ready   = !st_valid || !q_stat.full;
  assign accept        = items.valid && items.ready;
  assign is_text       = (op_t'(items.operation) == OP_TEXT);
  assign in_alpha_idx  = (32'(items.table_index) < ALPHABET_SIZE);
  assign in_alpha_byte = (32'(items.text_byte) < ALPHABET_SIZE);

  // table write on load, registered read on text byte
  always_ff @(posedge clk) begin
    if (accept && !is_text && in_alpha_idx) begin
      char_table[items.table_index[TIDX_W-1:0]] <= items.table_word;
    end
    if (accept && is_text) begin
      rd_word <= char_table[items.text_byte[TIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (accept && is_text) begin
      st_valid <= 1'b1;
    end else if (q_push) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_text) begin
      st_in_alpha <= in_alpha_byte;
      st_first    <= items.first_of_text;
      st_start    <= items.start_position;
      st_last     <= items.last_of_text;
    end
  end

  assign q_push       = st_valid && !q_stat.full;
  assign q_data.inc   = st_in_alpha ? rd_word : 64'd0;
  assign q_data.first = st_first;
  assign q_data.start = st_start;
  assign q_data.last  = st_last;

endmodule

@@ sv/smm_queue.sv @@
// short fifo between front and back
module smm_queue import smm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output q_entry_t pop_data,
  output q_stat_t  stat
);

  q_entry_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (32'(wr_ptr) == QDEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (32'(rd_ptr) == QDEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_data   = slots[rd_ptr];
  assign stat.full  = (32'(count) == QDEPTH);
  assign stat.empty = (count == '0);
  assign stat.count = count;

endmodule

@@ sv/smm_back.sv @@
// back end: shift-add counter update, then limit compare and match count
module smm_back import smm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  q_stat_t  q_stat,
  input  q_entry_t q_data,
  output logic     q_pop,
  smm_out_if.source results
);

  logic             advance;
  logic [63:0]      wmask;
  logic [63:0]      cw_base;
  logic [63:0]      ow_base;
  logic [63:0]      sum;
  logic [63:0]      cw_next;
  logic [63:0]      ow_next;
  logic [POS_W-1:0] pos_next;

  logic [63:0]      cw;
  logic [63:0]      ow;
  logic [POS_W-1:0] pos;
  logic             s1_valid;
  logic             s1_first;
  logic             s1_last;

  logic             hit;
  logic [POS_W-1:0] count_base;
  logic [POS_W-1:0] count_next;
  logic [POS_W-1:0] found_count;

  logic             out_valid;
  logic             out_found;
  logic [POS_W-1:0] out_end;
  logic [POS_W-1:0] out_count;
  logic             out_last;

  assign advance = !out_valid || results.ready;
  assign q_pop   = advance && !q_stat.empty;
  assign wmask   = cfg.word_mask & ALL_WORD_BITS;

  // stage one: the loop-carried counter and overflow words
  always_comb begin
    cw_base  = q_data.first ? (wmask & ~cfg.overflow_mask) : cw;
    ow_base  = q_data.first ? (wmask & cfg.overflow_mask) : ow;
    sum      = ((cw_base << cfg.field_bits) + q_data.inc) & wmask;
    ow_next  = ((ow_base << cfg.field_bits) | (sum & cfg.overflow_mask)) & wmask;
    cw_next  = sum & ~cfg.overflow_mask;
    pos_next = (q_data.first ? q_data.start : pos) + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cw       <= '0;
      ow       <= '0;
      pos      <= '0;
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= !q_stat.empty;
      if (q_pop) begin
        cw  <= cw_next;
        ow  <= ow_next;
        pos <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_first <= q_data.first;
      s1_last  <= q_data.last;
    end
  end

  // stage two: compare and saturating count
  always_comb begin
    hit        = (cw + ow) < cfg.match_limit;
    count_base = s1_first ? '0 : found_count;
    count_next = (hit && count_base != COUNT_MAX) ? count_base + 1'b1 : count_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found_count <= '0;
      out_valid   <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        found_count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_found <= hit;
      out_end   <= pos;
      out_count <= count_next;
      out_last  <= s1_last;
    end
  end

  assign results.valid       = out_valid;
  assign results.match_found = out_found;
  assign results.match_end   = out_end;
  assign results.match_count = out_count;
  assign results.last        = out_last;

endmodule

@@ sv/shift_add_mismatch_matcher.sv @@
// top level of the shift-add mismatch matcher
// usage:
//   items carries load transactions (operation 0: table_index, table_word)
//   and text transactions (operation 1: text_byte, first_of_text,
//   start_position, last_of_text). results carries one transaction per text
//   byte and none per load.
//   configuration registers are written through cfg_we, cfg_index, cfg_data
//   while no transaction is in flight.
// timing:
//   one transaction per cycle sustained while results.ready is high; the
//   per-byte counter update in the back end is the loop that sets that rate.
//   a text byte's result becomes valid after the table read, the queue,
//   the counter stage and the compare stage into the output register.
//   a load is visible to a text byte accepted in the next cycle.
// reset:
//   rst clears the pipeline, queue, counter words, position and match count
//   and sets the registers to their defaults; the table holds stale data.
// stall:
//   when results.ready is low the back end holds; the output register, the
//   compare stage, the two-entry queue and the lookup register hold up to
//   five text bytes before items.ready drops.
`include "assert_macros.svh"

module shift_add_mismatch_matcher import smm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  smm_in_if.sink      items,
  smm_out_if.source   results
);

  cfg_t     cfg;
  q_stat_t  q_stat;
  q_entry_t q_in;
  q_entry_t q_out;
  logic     q_push;
  logic     q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.field_bits    <= FIELD_W'(4);
      cfg.word_mask     <= '1;
      cfg.overflow_mask <= '0;
      cfg.match_limit   <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_FIELD_BITS:    cfg.field_bits    <= cfg_data[FIELD_W-1:0];
        REG_WORD_MASK:     cfg.word_mask     <= cfg_data;
        REG_OVERFLOW_MASK: cfg.overflow_mask <= cfg_data;
        REG_MATCH_LIMIT:   cfg.match_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  smm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_in)
  );

  smm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  smm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_stat  (q_stat),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .results (results)
  );

  `SMM_ASSERT_NOW(a_no_push_full, clk, rst, q_push, !q_stat.full, "push into full queue")
  `SMM_ASSERT_NOW(a_no_pop_empty, clk, rst, q_pop, !q_stat.empty, "pop from empty queue")
  `SMM_ASSERT_NEXT(a_count_track, clk, rst, q_push && !q_pop, q_stat.count == $past(q_stat.count) + 1'b1, "queue count lost a push")

endmodule
